// ----- src/wbps_pkg.sv -----
// shared types, codes and constants of the wildcard byte pattern scanner
package wbps_pkg;

  // default pattern capacity
  localparam int PATTERN_MAX_DEF = 32;

  // field widths
  localparam int LEN_W      = 6;
  localparam int MODE_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 5;
  localparam int OFFSET_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_VALUE   = 2'd2;

  // match modes
  localparam logic [MODE_W-1:0] MODE_MASK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IGNORE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd2;

  // operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // register reset values ('*' is the default ignore byte)
  localparam logic [LEN_W-1:0]  LEN_RST    = 6'd1;
  localparam logic [MODE_W-1:0] MODE_RST   = MODE_MASK;
  localparam logic [BYTE_W-1:0] IGNORE_RST = 8'h2A;

  // input transaction
  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  pattern_index;
    logic [BYTE_W-1:0] byte_value;
    logic              wildcard_mark;
    logic              last_byte;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } out_item_t;

  // pattern load write
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] byte_value;
    logic              mark;
  } ld_ctrl_t;

  // window shift control
  typedef struct packed {
    logic              shift;
    logic [BYTE_W-1:0] byte_value;
  } win_ctrl_t;

endpackage

// ----- src/wildcard_byte_pattern_scanner_top.sv -----
// top level of the wildcard byte pattern scanner
// Takes one transaction per cycle, either a pattern load or a region byte, and
// returns at most one result per region: the start offset of the first window
// that matches the pattern, or not found when the last byte passes without a
// match. Each transaction is held in the input register and is then processed
// into the result register, from which the result is offered; a new
// transaction is taken every cycle while the result side does not stall;
// the window shift, the full-width masked compare and the saturating byte
// counter all act in the same cycle, as the transaction leaves the input
// register. Loads take effect for the very next region byte. Configuration
// must be written by the user only while idle; the block does not enforce it.
module wildcard_byte_pattern_scanner_top #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wbps_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wbps_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int OW = wbps_pkg::OFFSET_W;

  logic [wbps_pkg::LEN_W-1:0]  len_cfg_r;
  logic [wbps_pkg::MODE_W-1:0] mode_r;
  logic [wbps_pkg::BYTE_W-1:0] ignore_r;
  logic [LW-1:0]               used_len;

  logic                        in_vld_r;
  wbps_pkg::in_item_t          in_item_r;
  logic                        proc_go;
  logic                        is_scan;

  logic [OW-1:0]               bytes_seen_r;
  logic [OW-1:0]               bytes_seen_nxt;
  logic [OW-1:0]               seen_inc;
  logic                        reported_r;
  logic                        reported_nxt;

  logic                        out_valid_r;
  wbps_pkg::out_item_t         out_data_r;
  wbps_pkg::out_item_t         res;
  logic                        emit;

  wbps_pkg::ld_ctrl_t          ld;
  wbps_pkg::win_ctrl_t         win_ctrl;
  logic [PATTERN_MAX*wbps_pkg::BYTE_W-1:0] pat_flat;
  logic [PATTERN_MAX-1:0]      wild_vec;
  logic                        win_match;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= wbps_pkg::LEN_RST;
      mode_r    <= wbps_pkg::MODE_RST;
      ignore_r  <= wbps_pkg::IGNORE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wbps_pkg::REG_PATTERN_LENGTH: len_cfg_r <= cfg_data[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_MATCH_MODE:     mode_r    <= cfg_data[wbps_pkg::MODE_W-1:0];
        wbps_pkg::REG_IGNORE_VALUE:   ignore_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the configured length into 1..PATTERN_MAX
  always_comb begin
    if (len_cfg_r == '0) begin
      used_len = LW'(1);
    end else if (32'(len_cfg_r) > 32'(PATTERN_MAX)) begin
      used_len = LW'(PATTERN_MAX);
    end else begin
      used_len = LW'(len_cfg_r);
    end
  end

  // input register
  assign proc_go  = in_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = in_vld_r && !proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (proc_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // store and window control
  assign is_scan = proc_go && (in_item_r.operation == wbps_pkg::OP_SCAN);

  assign ld.we         = proc_go && (in_item_r.operation == wbps_pkg::OP_LOAD);
  assign ld.index      = in_item_r.pattern_index;
  assign ld.byte_value = in_item_r.byte_value;
  assign ld.mark       = in_item_r.wildcard_mark;

  assign win_ctrl.shift      = is_scan;
  assign win_ctrl.byte_value = in_item_r.byte_value;

  wbps_pattern_store #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_store (
    .clk          (clk),
    .ld           (ld),
    .mode         (mode_r),
    .ignore_value (ignore_r),
    .pat_flat     (pat_flat),
    .wild_vec     (wild_vec)
  );

  wbps_window_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .LW          (LW)
  ) u_window (
    .clk      (clk),
    .ctrl     (win_ctrl),
    .used_len (used_len),
    .pat_flat (pat_flat),
    .wild_vec (wild_vec),
    .match    (win_match)
  );

  // byte count, report tracking and result selection
  assign seen_inc = (bytes_seen_r == '1) ? bytes_seen_r : bytes_seen_r + OW'(1);

  always_comb begin
    emit           = 1'b0;
    res            = '0;
    bytes_seen_nxt = bytes_seen_r;
    reported_nxt   = reported_r;
    if (is_scan) begin
      bytes_seen_nxt = seen_inc;
      if (!reported_r && (seen_inc >= OW'(used_len)) && win_match) begin
        emit             = 1'b1;
        res.found        = 1'b1;
        res.match_offset = seen_inc - OW'(used_len);
        if (in_item_r.last_byte) begin
          bytes_seen_nxt = '0;
          reported_nxt   = 1'b0;
        end else begin
          reported_nxt   = 1'b1;
        end
      end else if (in_item_r.last_byte) begin
        bytes_seen_nxt = '0;
        reported_nxt   = 1'b0;
        emit           = !reported_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      reported_r   <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      reported_r   <= reported_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/wbps_pattern_store.sv -----
// pattern and wildcard mark storage with per-mode wildcard resolution
module wbps_pattern_store #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                             clk,
  input  wbps_pkg::ld_ctrl_t               ld,
  input  logic [wbps_pkg::MODE_W-1:0]      mode,
  input  logic [wbps_pkg::BYTE_W-1:0]      ignore_value,
  output logic [PATTERN_MAX*wbps_pkg::BYTE_W-1:0] pat_flat,
  output logic [PATTERN_MAX-1:0]           wild_vec
);

  localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [wbps_pkg::BYTE_W-1:0] pat_r [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]      wc_r;

  // load write, indexes beyond the store are dropped
  always_ff @(posedge clk) begin
    if (ld.we && (32'(ld.index) < 32'(PATTERN_MAX))) begin
      pat_r[PIW'(ld.index)] <= ld.byte_value;
      wc_r[PIW'(ld.index)]  <= ld.mark;
    end
  end

  // flatten pattern and resolve wildcards for the current mode
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat_flat[i*wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W] = pat_r[i];
      case (mode)
        wbps_pkg::MODE_MASK:   wild_vec[i] = wc_r[i];
        wbps_pkg::MODE_IGNORE: wild_vec[i] = (pat_r[i] == ignore_value);
        default:               wild_vec[i] = 1'b0;
      endcase
    end
  end

endmodule

// ----- src/wbps_window_match.sv -----
// sliding byte window and parallel masked compare against the pattern
module wbps_window_match #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  parameter int LW          = $clog2(PATTERN_MAX + 1)
) (
  input  logic                                    clk,
  input  wbps_pkg::win_ctrl_t                     ctrl,
  input  logic [LW-1:0]                           used_len,
  input  logic [PATTERN_MAX*wbps_pkg::BYTE_W-1:0] pat_flat,
  input  logic [PATTERN_MAX-1:0]                  wild_vec,
  output logic                                    match
);

  localparam int BW = wbps_pkg::BYTE_W;
  localparam logic [LW-1:0] PMAX_L = LW'(PATTERN_MAX);

  logic [PATTERN_MAX*BW-1:0] win_r;
  logic [PATTERN_MAX*BW-1:0] win_nxt;
  logic [PATTERN_MAX*BW-1:0] aligned;
  logic [LW-1:0]             base;
  logic [PATTERN_MAX-1:0]    ok;

  // newest byte enters at the top, oldest drops out at the bottom
  assign win_nxt = {ctrl.byte_value, win_r[PATTERN_MAX*BW-1:BW]};

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      win_r <= win_nxt;
    end
  end

  // bring the last used_len window bytes down to pattern position zero
  assign base    = PMAX_L - used_len;
  assign aligned = win_nxt >> {base, 3'b000};

  // per-byte compare, unused pattern positions always pass
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      ok[i] = (LW'(i) >= used_len) || wild_vec[i] ||
              (pat_flat[i*BW +: BW] == aligned[i*BW +: BW]);
    end
  end

  assign match = &ok;

endmodule
